>>> rtl/mulaw_error_feedback_encoder_macros.svh
// ----------------------------------------------------------------------------
// mu-law error feedback encoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULAW_ERROR_FEEDBACK_ENCODER_MACROS_SVH
`define MULAW_ERROR_FEEDBACK_ENCODER_MACROS_SVH

// same-cycle implication
`define MLEFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLEFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mlefe_pkg.sv
// ----------------------------------------------------------------------------
// mlefe_pkg
// Widths, mu-law constants, result type and the encode/decode functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlefe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CODE_W   = 8;
  localparam int ERR_W    = 12;

  localparam int MULAW_BIAS = 132;
  localparam int MULAW_CLIP = 32767;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic [CODE_W-1:0]          code;
    logic signed [SAMPLE_W-1:0] reconstructed;
    logic signed [ERR_W-1:0]    feedback_error;
  } mlefe_result_t;

  function automatic logic [CODE_W-1:0] mulaw_encode(input logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W:0] sx;
    logic [SAMPLE_W:0]        mag;
    logic [SAMPLE_W:0]        biased;
    logic [14:0]              clipped;
    logic [7:0]               top;
    logic [2:0]               ex;
    logic [14:0]              shifted;
    logic                     sign;
    sx      = {s[SAMPLE_W-1], s};
    sign    = ~s[SAMPLE_W-1];
    mag     = s[SAMPLE_W-1] ? (SAMPLE_W+1)'(-sx) : (SAMPLE_W+1)'(sx);
    biased  = mag + (SAMPLE_W+1)'(MULAW_BIAS);
    clipped = (biased > (SAMPLE_W+1)'(MULAW_CLIP)) ? 15'(MULAW_CLIP) : biased[14:0];
    top     = clipped[14:7];
    ex      = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (top[i]) begin
        ex = 3'(i);
      end
    end
    shifted = clipped >> (4'(ex) + 4'd3);
    return ~{sign, ex, shifted[3:0]};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mulaw_decode(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0]        u;
    logic [2:0]               ex;
    logic [14:0]              mag15;
    logic signed [SAMPLE_W:0] magd;
    logic signed [SAMPLE_W:0] negd;
    u     = ~code;
    ex    = u[6:4];
    mag15 = 15'({1'b1, u[3:0]}) << (4'(ex) + 4'd3);
    magd  = $signed({2'b00, mag15}) - (SAMPLE_W+1)'(MULAW_BIAS);
    negd  = -magd;
    return u[7] ? magd[SAMPLE_W-1:0] : negd[SAMPLE_W-1:0];
  endfunction

endpackage

>>> rtl/mlefe_if.sv
// ----------------------------------------------------------------------------
// mlefe_in_if / mlefe_out_if
// Valid/ready channels for input samples and encoded results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mlefe_in_if;
  import mlefe_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface mlefe_out_if;
  import mlefe_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CODE_W-1:0]          code;
  logic signed [SAMPLE_W-1:0] reconstructed;
  logic signed [ERR_W-1:0]    feedback_error;

  modport source (output valid, code, reconstructed, feedback_error, input ready);
  modport sink   (input valid, code, reconstructed, feedback_error, output ready);
endinterface

>>> rtl/mlefe_codec.sv
// ----------------------------------------------------------------------------
// mlefe_codec
// Adds carried error, saturates, mu-law encodes, decodes and forms new error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlefe_codec (
  input  logic signed [mlefe_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [mlefe_pkg::ERR_W-1:0]    carried_err,
  output mlefe_pkg::mlefe_result_t              result
);
  import mlefe_pkg::*;

  logic signed [SAMPLE_W:0]   sum_wide;
  logic signed [SAMPLE_W-1:0] sum_sat;
  logic [CODE_W-1:0]          code;
  logic signed [SAMPLE_W-1:0] rec;
  logic signed [SAMPLE_W:0]   err_wide;

  assign sum_wide = {sample[SAMPLE_W-1], sample}
                  + {{(SAMPLE_W+1-ERR_W){carried_err[ERR_W-1]}}, carried_err};

  always_comb begin
    if (sum_wide[SAMPLE_W] != sum_wide[SAMPLE_W-1]) begin
      sum_sat = sum_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      sum_sat = sum_wide[SAMPLE_W-1:0];
    end
  end

  assign code     = mulaw_encode(sum_sat);
  assign rec      = mulaw_decode(code);
  assign err_wide = {sum_sat[SAMPLE_W-1], sum_sat} - {rec[SAMPLE_W-1], rec};

  assign result.code           = code;
  assign result.reconstructed  = rec;
  assign result.feedback_error = err_wide[ERR_W-1:0];

endmodule

>>> rtl/mulaw_error_feedback_encoder.sv
// ----------------------------------------------------------------------------
// mulaw_error_feedback_encoder
// mu-law sample encoder with quantization error feedback.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                    handshake
//   in_ch    in   sample[15:0] s, last_sample                valid/ready
//   out_ch   out  code[7:0], reconstructed[15:0] s,          valid/ready
//                 feedback_error[11:0] s
//
// One sample per cycle while results are taken; each sample passes through the
// input stage register and then the result register. Carried error loop
// closes through the codec between the input stage and the result register.
// Synchronous active-low reset empties both stages and zeroes the error.
// A stalled result holds the input stage; a full input stage refuses input until the result drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mulaw_error_feedback_encoder_macros.svh"

module mulaw_error_feedback_encoder (
  input  logic        clk,
  input  logic        rst_n,
  mlefe_in_if.sink    in_ch,
  mlefe_out_if.source out_ch
);
  import mlefe_pkg::*;

  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r, s1_sample_nxt;
  logic                       s1_last_r, s1_last_nxt;
  logic signed [ERR_W-1:0]    carried_err_r, carried_err_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mlefe_result_t              out_res_r, out_res_nxt;
  mlefe_result_t              codec_res;
  logic                       s1_adv;
  logic                       in_xfer;

  mlefe_codec u_codec (
    .sample      (s1_sample_r),
    .carried_err (carried_err_r),
    .result      (codec_res)
  );

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt    = s1_valid_r;
    s1_sample_nxt   = s1_sample_r;
    s1_last_nxt     = s1_last_r;
    carried_err_nxt = carried_err_r;
    out_valid_nxt   = out_valid_r;
    out_res_nxt     = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_nxt    = 1'b0;
      out_valid_nxt   = 1'b1;
      out_res_nxt     = codec_res;
      carried_err_nxt = s1_last_r ? '0 : codec_res.feedback_error;
    end
    if (in_xfer) begin
      s1_valid_nxt  = 1'b1;
      s1_sample_nxt = in_ch.sample;
      s1_last_nxt   = in_ch.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      carried_err_r <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      carried_err_r <= carried_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample_r <= s1_sample_nxt;
    s1_last_r   <= s1_last_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.code           = out_res_r.code;
  assign out_ch.reconstructed  = out_res_r.reconstructed;
  assign out_ch.feedback_error = out_res_r.feedback_error;

  `MLEFE_ASSERT_NEXT(a_err_hold, !s1_adv, $stable(carried_err_r), "error changed without transfer")
  `MLEFE_ASSERT_NEXT(a_err_clear, s1_adv && s1_last_r, carried_err_r == '0, "error not cleared")
  `MLEFE_ASSERT_NEXT(a_err_carry, s1_adv && !s1_last_r,
                     carried_err_r == out_res_r.feedback_error, "carried error mismatch")

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: mulaw_error_feedback_encoder testbench
// Sends signed PCM samples over the input channel and predicts each result
// of the mu-law encoder with error feedback. Results are checked field by
// field, in order. The run covers directed corner samples, then several
// random phases with sender and receiver stalls, one long receiver hold-off,
// and a final phase with no stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mlefe_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       end_of_sound;
  } pcm_item_t;

  logic clk;
  logic rst_n;

  mlefe_in_if  in_ch ();
  mlefe_out_if out_ch ();

  mulaw_error_feedback_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  pcm_item_t     pcm_q[$];
  mlefe_result_t code_q[$];

  int   carry_err;
  logic in_took;
  int   tx_gap, rx_gap, hold_left;
  int   tx_idle_pct, rx_idle_pct;
  bit   hold_req, hold_armed;
  int   cycle_cnt;
  int   n_in, n_out, n_sounds, n_sat, fail_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt, code_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sum is already saturated to 16 bits
  function automatic mlefe_result_t mulaw_feedback_code(input int sum, output int err);
    mlefe_result_t r;
    bit            pos;
    int            mag, biased, ex, mant, rec;
    pos    = (sum >= 0);
    mag    = pos ? sum : -sum;
    biased = mag + MULAW_BIAS;
    if (biased > MULAW_CLIP) biased = MULAW_CLIP;
    ex = 0;
    for (int i = 1; i < 8; i++) begin
      if ((biased >> (7 + i)) != 0) ex = i;
    end
    mant = (biased >> (ex + 3)) & 15;
    rec  = ((mant + 16) << (ex + 3)) - MULAW_BIAS;
    if (!pos) rec = -rec;
    err = sum - rec;
    r.code           = ~{pos, 3'(ex), 4'(mant)};
    r.reconstructed  = SAMPLE_W'(rec);
    r.feedback_error = ERR_W'(err);
    return r;
  endfunction

  // input transfers feed the predictor; result transfers are checked
  always @(posedge clk) begin
    mlefe_result_t want;
    int            sum, err;
    if (!rst_n) begin
      in_took   <= 1'b0;
      carry_err = 0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        sum = int'(in_ch.sample) + carry_err;
        if (sum > 32767 || sum < -32768) n_sat++;
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        code_q.push_back(mulaw_feedback_code(sum, err));
        carry_err = in_ch.last_sample ? 0 : err;
        if (in_ch.last_sample) n_sounds++;
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (code_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result with none expected: code %02h rec %0d err %0d", $realtime,
                     out_ch.code, out_ch.reconstructed, out_ch.feedback_error);
        end else begin
          want = code_q.pop_front();
          if (out_ch.code !== want.code || out_ch.reconstructed !== want.reconstructed ||
              out_ch.feedback_error !== want.feedback_error) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: result %0d: exp code/rec/err %02h/%0d/%0d, got %02h/%0d/%0d",
                       $realtime, n_out, want.code, want.reconstructed, want.feedback_error,
                       out_ch.code, out_ch.reconstructed, out_ch.feedback_error);
          end
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    pcm_item_t nxt;
    logic      v_n;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      v_n = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pcm_q.size() != 0 && tx_idle_pct != 0 &&
                   $urandom_range(0, 99) < tx_idle_pct) begin
        tx_gap = $urandom_range(0, 15);
      end else if (pcm_q.size() != 0) begin
        nxt = pcm_q.pop_front();
        in_ch.sample      <= nxt.pcm;
        in_ch.last_sample <= nxt.end_of_sound;
        v_n = 1'b1;
      end
      in_ch.valid <= v_n;
    end
  end

  // receiver
  always @(negedge clk) begin
    logic r_n;
    r_n = 1'b1;
    if (!rst_n) begin
      r_n = 1'b0;
    end else begin
      if (hold_req && !hold_armed) begin
        hold_armed = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        r_n = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        r_n = 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(0, 15);
        r_n = 1'b0;
      end
    end
    out_ch.ready <= r_n;
  end

  initial begin
    int dir_vals[] = '{0, 1, -1, 4, -4, 123, 124, -123, -124, 32635, 32636, 32767,
                       32767, 32767, -32635, -32636, -32768, -32768, -32768, 21845,
                       -21846, 1000, -1000};
    bit dir_last[] = '{1, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0,
                       0, 1, 0, 0, 0, 0, 1, 0,
                       0, 0, 1};
    int tx_tab[NUM_PHASES] = '{10, 0, 30, 5, 20, 0};
    int rx_tab[NUM_PHASES] = '{10, 0, 5, 30, 20, 0};
    int extremes[8] = '{32767, -32768, 32635, 32636, -32635, -32636, 0, -1};
    int v, walk, n_pushed;
    pcm_item_t it;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.last_sample  = 1'b0;
    out_ch.ready       = 1'b0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    walk               = 0;
    n_pushed           = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (dir_vals[i]) begin
      it.pcm          = SAMPLE_W'(dir_vals[i]);
      it.end_of_sound = dir_last[i];
      pcm_q.push_back(it);
      n_pushed++;
    end

    for (int p = 0; p <= NUM_PHASES; p++) begin
      // sender pause: nothing new until every result is back
      do @(negedge clk);
      while (n_out != n_pushed);
      @(posedge clk);
      if (p == NUM_PHASES) break;
      tx_idle_pct = tx_tab[p];
      rx_idle_pct = rx_tab[p];
      if (p == 1) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: v = int'(signed'(SAMPLE_W'($urandom)));
          4, 5:       v = int'($urandom_range(0, 600)) - 300;
          6, 7: begin
            walk = walk + int'($urandom_range(0, 4000)) - 2000;
            if (walk > 32767) walk = 32767;
            if (walk < -32768) walk = -32768;
            v = walk;
          end
          8:       v = extremes[$urandom_range(0, 7)];
          default: v = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 1500))
                                            : -32768 + int'($urandom_range(0, 1500));
        endcase
        it.pcm          = SAMPLE_W'(v);
        it.end_of_sound = ($urandom_range(0, 15) == 0);
        pcm_q.push_back(it);
        n_pushed++;
      end
    end

    repeat (10) @(posedge clk);
    $display("Encoded %0d samples over %0d sound ends, %0d with saturated sum,",
             n_in, n_sounds, n_sat);
    $display("checked %0d results with stalls and a %0d-cycle hold-off; %0d mismatches",
             n_out, HOLD_CYCLES, fail_cnt);
    if (fail_cnt == 0 && code_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
